@@ rtl/hslrgb_pkg.sv @@
package hslrgb_pkg;

  // Register stages from the input side to the output register.
  localparam int NUM_STAGES = 7;

  // Stage indexes into the enable and valid vectors.
  localparam int STG_MIX   = 0;  // clamp inputs, lightness times saturation
  localparam int STG_PQ    = 1;  // q, p and their difference
  localparam int STG_SEG   = 2;  // shifted hue, ramp segment, ramp argument
  localparam int STG_MUL   = 3;  // slope product
  localparam int STG_RAMP  = 4;  // ramp value, limited to one
  localparam int STG_SCALE = 5;  // channel scale product
  localparam int STG_OUT   = 6;  // saturated channel, output register

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  // Load enables and valid bits of every stage, driven by the top level.
  typedef struct packed {
    stage_vec_t en;
    stage_vec_t vld;
  } pipe_ctl_t;

  // Piece of the hue ramp that a shifted hue falls into.
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HOLD,
    SEG_FALL,
    SEG_FLOOR
  } ramp_seg_e;

  // Hue offset of one color channel.
  typedef enum logic [1:0] {
    HUE_PLUS_THIRD,
    HUE_SAME,
    HUE_MINUS_THIRD
  } hue_shift_e;

endpackage

@@ rtl/hslrgb_chroma.sv @@
module hslrgb_chroma #(
  parameter int FRAC_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hslrgb_pkg::pipe_ctl_t  ctl_i,
  input  logic [FRAC_BITS-1:0]   hue_i,
  input  logic [FRAC_BITS:0]     saturation_i,
  input  logic [FRAC_BITS:0]     lightness_i,
  output logic [FRAC_BITS-1:0]   hue_o,
  output logic [FRAC_BITS+1:0]   p_o,
  output logic [FRAC_BITS+1:0]   q_o,
  output logic [FRAC_BITS+1:0]   d_o
);

  localparam int FB = FRAC_BITS;
  localparam logic [FB:0] ONE  = (FB+1)'(1) << FB;
  localparam logic [FB:0] HALF = (FB+1)'(1) << (FB - 1);

  logic [FB:0]      s_c, l_c;
  logic [2*FB+1:0]  ls_full;

  logic [FB-1:0]    hue_mix_q;
  logic [FB:0]      s_q, l_q, ls_q;
  logic             l_low_q;

  logic [FB+1:0]    q_raw, two_l, q_g, p_d;

  logic [FB-1:0]    hue_pq_q;
  logic [FB+1:0]    p_q, q_q, d_q;

  // Stage one: limit the fractions to one and form l*s.
  always_comb begin
    s_c     = (saturation_i > ONE) ? ONE : saturation_i;
    l_c     = (lightness_i > ONE) ? ONE : lightness_i;
    ls_full = (2*FB+2)'(l_c) * (2*FB+2)'(s_c);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[hslrgb_pkg::STG_MIX]) begin
      hue_mix_q <= hue_i;
      s_q       <= s_c;
      l_q       <= l_c;
      ls_q      <= ls_full[2*FB:FB];
      l_low_q   <= (l_c < HALF);
    end
  end

  // Stage two: q, then p = 2l - q; the difference drives the ramp slope.
  always_comb begin
    two_l = {l_q, 1'b0};
    if (l_low_q) begin
      q_raw = (FB+2)'(l_q) + (FB+2)'(ls_q);
    end else begin
      q_raw = (FB+2)'(l_q) + (FB+2)'(s_q) - (FB+2)'(ls_q);
    end
    q_g = (q_raw > two_l) ? two_l : q_raw;
    p_d = two_l - q_g;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[hslrgb_pkg::STG_PQ]) begin
      hue_pq_q <= hue_mix_q;
      p_q      <= p_d;
      q_q      <= q_g;
      d_q      <= {q_g[FB:0], 1'b0} - two_l;
    end
  end

  assign hue_o = hue_pq_q;
  assign p_o   = p_q;
  assign q_o   = q_q;
  assign d_o   = d_q;

  a_p_below_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.vld[hslrgb_pkg::STG_PQ] |-> (p_q <= q_q) && (d_q == q_q - p_q))
    else $error("p above q or slope mismatch");

endmodule

@@ rtl/hslrgb_ramp.sv @@
module hslrgb_ramp #(
  parameter int                     FRAC_BITS    = 12,
  parameter int                     CHANNEL_BITS = 8,
  parameter hslrgb_pkg::hue_shift_e SHIFT        = hslrgb_pkg::HUE_SAME
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hslrgb_pkg::pipe_ctl_t   ctl_i,
  input  logic [FRAC_BITS-1:0]    hue_i,
  input  logic [FRAC_BITS+1:0]    p_i,
  input  logic [FRAC_BITS+1:0]    q_i,
  input  logic [FRAC_BITS+1:0]    d_i,
  output logic [CHANNEL_BITS-1:0] chan_o
);

  localparam int FB = FRAC_BITS;
  localparam int CB = CHANNEL_BITS;
  localparam logic [FB-1:0] THIRD      = FB'((1 << FB) / 3);
  localparam logic [FB-1:0] TWO_THIRDS = FB'((2 * (1 << FB)) / 3);
  localparam logic [FB-1:0] OFFSET =
    (SHIFT == hslrgb_pkg::HUE_PLUS_THIRD)  ? THIRD :
    (SHIFT == hslrgb_pkg::HUE_MINUS_THIRD) ? FB'((1 << FB) - (1 << FB) / 3) :
    FB'(0);
  localparam logic [FB+2:0] ONE_X     = (FB+3)'(1) << FB;
  localparam logic [FB+2:0] TWO_ONE_X = (FB+3)'(2) << FB;
  localparam logic [FB+5:0] ONE_S     = (FB+6)'(1) << FB;
  localparam logic [FB:0]   ONE       = (FB+1)'(1) << FB;
  localparam logic [CB:0]   CMAX_W    = ((CB+1)'(1) << CB) - (CB+1)'(1);
  localparam logic [CB-1:0] CMAX      = CMAX_W[CB-1:0];

  logic [FB-1:0]        t, arg;
  logic [FB+2:0]        t_x;
  hslrgb_pkg::ramp_seg_e seg_d;

  hslrgb_pkg::ramp_seg_e seg_q, seg_mul_q;
  logic [FB+2:0]        arg6_q;
  logic [FB+1:0]        p_seg_q, q_seg_q, d_seg_q;
  logic [FB+1:0]        p_mul_q, q_mul_q;
  logic [2*FB+4:0]      prod_q;

  logic [FB+5:0]        sum;
  logic [FB:0]          c_d, c_q;
  logic [FB+CB:0]       scale_q;
  logic [CB:0]          chan_full;
  logic [CB-1:0]        chan_q;

  // Shifted hue, wrapped once, and the piece of the ramp it lands in.
  always_comb begin
    t   = hue_i + OFFSET;
    t_x = (FB+3)'(t);
    if ((t_x * (FB+3)'(6)) < ONE_X) begin
      seg_d = hslrgb_pkg::SEG_RISE;
    end else if ((t_x << 1) < ONE_X) begin
      seg_d = hslrgb_pkg::SEG_HOLD;
    end else if ((t_x * (FB+3)'(3)) < TWO_ONE_X) begin
      seg_d = hslrgb_pkg::SEG_FALL;
    end else begin
      seg_d = hslrgb_pkg::SEG_FLOOR;
    end
    arg = (seg_d == hslrgb_pkg::SEG_RISE) ? t : (TWO_THIRDS - t);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[hslrgb_pkg::STG_SEG]) begin
      seg_q   <= seg_d;
      arg6_q  <= (FB+3)'(arg) * (FB+3)'(6);
      p_seg_q <= p_i;
      q_seg_q <= q_i;
      d_seg_q <= d_i;
    end
  end

  // Slope product (q-p)*6*arg.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[hslrgb_pkg::STG_MUL]) begin
      seg_mul_q <= seg_q;
      p_mul_q   <= p_seg_q;
      q_mul_q   <= q_seg_q;
      prod_q    <= (2*FB+5)'(d_seg_q) * (2*FB+5)'(arg6_q);
    end
  end

  // Ramp value for the segment, limited to one.
  always_comb begin
    case (seg_mul_q)
      hslrgb_pkg::SEG_RISE,
      hslrgb_pkg::SEG_FALL: sum = (FB+6)'(p_mul_q) + (FB+6)'(prod_q[2*FB+4:FB]);
      hslrgb_pkg::SEG_HOLD: sum = (FB+6)'(q_mul_q);
      default:              sum = (FB+6)'(p_mul_q);
    endcase
    c_d = (sum > ONE_S) ? ONE : sum[FB:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[hslrgb_pkg::STG_RAMP]) begin
      c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[hslrgb_pkg::STG_SCALE]) begin
      scale_q <= (FB+CB+1)'(c_q) * (FB+CB+1)'(CMAX);
    end
  end

  assign chan_full = scale_q[FB+CB:FB];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[hslrgb_pkg::STG_OUT]) begin
      chan_q <= (chan_full > CMAX_W) ? CMAX : chan_full[CB-1:0];
    end
  end

  assign chan_o = chan_q;

  a_ramp_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.vld[hslrgb_pkg::STG_RAMP] |-> (c_q <= ONE))
    else $error("ramp value above one");

endmodule

@@ rtl/hsl_to_rgb_pixel.sv @@
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   hue[FRAC_BITS], saturation[FRAC_BITS+1], lightness[FRAC_BITS+1]
// m_axis    out  red[CHANNEL_BITS], green[CHANNEL_BITS], blue[CHANNEL_BITS]
//
// Each item passes seven register stages, from the stage that accepts it to the
// output register. One item is accepted every clock unless a stalled output has
// filled every stage; the throughput is set by the pipeline, whose longest step
// is one multiplier per stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output holds the last stage, and each earlier stage keeps
// moving until it meets a full stage, so empty slots are squeezed out.
module hsl_to_rgb_pixel #(
  parameter int FRAC_BITS    = 12,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // hue, saturation, lightness; zero padded to whole bytes
  input  logic [((3*FRAC_BITS+2+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // red, green, blue; zero padded to whole bytes
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int FB          = FRAC_BITS;
  localparam int CB          = CHANNEL_BITS;
  localparam int OUT_W       = 3 * CHANNEL_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int NS          = hslrgb_pkg::NUM_STAGES;

  hslrgb_pkg::stage_vec_t stg_vld_q, stg_en, vld_in;
  hslrgb_pkg::pipe_ctl_t  ctl;

  logic [FB-1:0] hue_in;
  logic [FB:0]   sat_in, light_in;
  logic [FB-1:0] hue_pq;
  logic [FB+1:0] p_pq, q_pq, d_pq;
  logic [CB-1:0] red, green, blue;

  // A stage may load when it is empty or when the stage after it moves.
  always_comb begin
    stg_en[NS-1] = ~stg_vld_q[NS-1] | m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      stg_en[k] = ~stg_vld_q[k] | stg_en[k+1];
    end
  end

  assign vld_in = {stg_vld_q[NS-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (stg_en[k]) begin
          stg_vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign ctl.en  = stg_en;
  assign ctl.vld = stg_vld_q;

  assign s_axis_tready_o = stg_en[0];
  assign m_axis_tvalid_o = stg_vld_q[NS-1];

  assign hue_in   = s_axis_tdata_i[FB-1:0];
  assign sat_in   = s_axis_tdata_i[2*FB:FB];
  assign light_in = s_axis_tdata_i[3*FB+1:2*FB+1];

  hslrgb_chroma #(
    .FRAC_BITS (FRAC_BITS)
  ) u_chroma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .hue_i        (hue_in),
    .saturation_i (sat_in),
    .lightness_i  (light_in),
    .hue_o        (hue_pq),
    .p_o          (p_pq),
    .q_o          (q_pq),
    .d_o          (d_pq)
  );

  // Red sits a third of a turn ahead of the hue, blue a third behind.
  hslrgb_ramp #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .SHIFT        (hslrgb_pkg::HUE_PLUS_THIRD)
  ) u_ramp_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .hue_i  (hue_pq),
    .p_i    (p_pq),
    .q_i    (q_pq),
    .d_i    (d_pq),
    .chan_o (red)
  );

  hslrgb_ramp #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .SHIFT        (hslrgb_pkg::HUE_SAME)
  ) u_ramp_green (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .hue_i  (hue_pq),
    .p_i    (p_pq),
    .q_i    (q_pq),
    .d_i    (d_pq),
    .chan_o (green)
  );

  hslrgb_ramp #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .SHIFT        (hslrgb_pkg::HUE_MINUS_THIRD)
  ) u_ramp_blue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .hue_i  (hue_pq),
    .p_i    (p_pq),
    .q_i    (q_pq),
    .d_i    (d_pq),
    .chan_o (blue)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({blue, green, red});

  // With every stage full and the output stalled, nothing may enter.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&stg_vld_q) && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("item accepted into a full pipeline");

  // Any empty slot, or a moving output, must open the input.
  a_room_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(&stg_vld_q) || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input held back with room in the pipeline");

  // A delivered result with nothing behind it leaves the output empty.
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !stg_vld_q[NS-2]) |=> !m_axis_tvalid_o)
    else $error("result repeated on the output");

endmodule

@@ tb/sv/tb.sv @@
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point layout of the block as instantiated below.
  localparam int FRAC_BITS    = 12;
  localparam int CHANNEL_BITS = 8;

  // Input item: hue[11:0], saturation[24:12], lightness[37:25], two pad bits on top.
  localparam int IN_W  = 40;
  // Result item: red[7:0], green[15:8], blue[23:16].
  localparam int OUT_W = 24;

  localparam longint unsigned ONE        = 64'd1 << FRAC_BITS;
  localparam longint unsigned FMASK      = ONE - 1;
  localparam longint unsigned THIRD      = ONE / 3;
  localparam longint unsigned TWO_THIRDS = (2 * ONE) / 3;
  localparam longint unsigned CMAX       = (64'd1 << CHANNEL_BITS) - 1;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 900;

  typedef struct packed {
    logic [1:0]  pad;
    logic [12:0] lightness;
    logic [12:0] saturation;
    logic [11:0] hue;
  } hsl_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_item_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  // Expected colors, oldest first, one per accepted item.
  rgb_item_t rgb_expect_q[$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned colors_checked;
  int unsigned gray_items;
  int unsigned clamped_items;
  int unsigned idle_cycles;

  // Idling on each side is switched on and off per phase of the run.
  bit src_idle_en;
  bit sink_idle_en;

  hsl_to_rgb_pixel #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Color prediction.
  // ---------------------------------------------------------------------------

  // Hue seen by one channel: red leads by a third of a turn, blue lags by one.
  function automatic longint unsigned channel_hue(longint unsigned hue,
                                                  hslrgb_pkg::hue_shift_e shift);
    case (shift)
      hslrgb_pkg::HUE_PLUS_THIRD:  return (hue + THIRD) & FMASK;
      hslrgb_pkg::HUE_MINUS_THIRD: return (hue + ONE - THIRD) & FMASK;
      default:                     return hue;
    endcase
  endfunction

  // Piecewise hue ramp between p and q; the slope product is truncated.
  function automatic longint unsigned ramp_level(longint unsigned p, longint unsigned q,
                                                 longint unsigned t);
    hslrgb_pkg::ramp_seg_e seg;
    longint unsigned       span;
    longint unsigned       level;
    span = q - p;
    if (6 * t < ONE)           seg = hslrgb_pkg::SEG_RISE;
    else if (2 * t < ONE)      seg = hslrgb_pkg::SEG_HOLD;
    else if (3 * t < 2 * ONE)  seg = hslrgb_pkg::SEG_FALL;
    else                       seg = hslrgb_pkg::SEG_FLOOR;
    case (seg)
      hslrgb_pkg::SEG_RISE:  level = p + ((span * 6 * t) >> FRAC_BITS);
      hslrgb_pkg::SEG_HOLD:  level = q;
      hslrgb_pkg::SEG_FALL:  level = p + ((span * 6 * (TWO_THIRDS - t)) >> FRAC_BITS);
      default:               level = p;
    endcase
    return (level > ONE) ? ONE : level;
  endfunction

  // Scale a fraction to the channel range, truncating and saturating.
  function automatic logic [7:0] scale_channel(longint unsigned frac);
    longint unsigned scaled;
    scaled = (frac * CMAX) >> FRAC_BITS;
    if (scaled > CMAX) scaled = CMAX;
    return scaled[7:0];
  endfunction

  function automatic rgb_item_t predict_rgb(logic [11:0] hue_in, logic [12:0] sat_in,
                                            logic [12:0] light_in);
    longint unsigned hue, sat, light, q, p;
    longint unsigned frac[3];
    rgb_item_t       rgb;
    hue   = hue_in;
    sat   = (sat_in > ONE) ? ONE : sat_in;
    light = (light_in > ONE) ? ONE : light_in;
    if (sat == 0) begin
      frac[0] = light;
      frac[1] = light;
      frac[2] = light;
    end else begin
      if (2 * light < ONE) q = light + ((light * sat) >> FRAC_BITS);
      else                 q = light + sat - ((light * sat) >> FRAC_BITS);
      if (q > 2 * light) q = 2 * light;
      p = 2 * light - q;
      frac[0] = ramp_level(p, q, channel_hue(hue, hslrgb_pkg::HUE_PLUS_THIRD));
      frac[1] = ramp_level(p, q, channel_hue(hue, hslrgb_pkg::HUE_SAME));
      frac[2] = ramp_level(p, q, channel_hue(hue, hslrgb_pkg::HUE_MINUS_THIRD));
    end
    rgb.red   = scale_channel(frac[0]);
    rgb.green = scale_channel(frac[1]);
    rgb.blue  = scale_channel(frac[2]);
    return rgb;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 35);
  endfunction

  // Sends one pixel and records its expected color once it is accepted.
  // Valid is only dropped when a gap is inserted, so back-to-back items keep
  // valid high without a second assignment in the same step.
  task automatic send_pixel(logic [11:0] hue, logic [12:0] sat, logic [12:0] light);
    int unsigned gap;
    hsl_item_t   item;
    gap = src_idle_en ? idle_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.pad        = '0;
    item.hue        = hue;
    item.saturation = sat;
    item.lightness  = light;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    rgb_expect_q.push_back(predict_rgb(hue, sat, light));
    items_sent++;
    if (sat == 0) gray_items++;
    if (sat > ONE || light > ONE) clamped_items++;
  endtask

  // Stops sending and waits until every expected color has come back, then
  // lets the pipeline run empty.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    wait (rgb_expect_q.size() == 0);
    repeat (hslrgb_pkg::NUM_STAGES + 3) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hue exactly on and next to every segment edge of the ramp, mostly at full
  // saturation, so each channel visits rise, hold, fall and floor.
  task automatic test_hue_segments();
    send_pixel(12'd0,    13'd4096, 13'd2048);
    send_pixel(12'd1365, 13'd4096, 13'd2048);
    send_pixel(12'd2730, 13'd4096, 13'd2048);
    send_pixel(12'd682,  13'd4096, 13'd2048);
    send_pixel(12'd683,  13'd4096, 13'd2048);
    send_pixel(12'd2047, 13'd4096, 13'd2048);
    send_pixel(12'd2048, 13'd4096, 13'd2048);
    send_pixel(12'd2731, 13'd4096, 13'd2047);
    send_pixel(12'd4095, 13'd4096, 13'd2049);
    send_pixel(12'd3413, 13'd2048, 13'd1024);
  endtask

  // Gray pixels, inputs at and beyond one, the lightness threshold at one
  // half and alternating bit patterns.
  task automatic test_range_limits();
    send_pixel(12'd0,     13'd0,      13'd0);
    send_pixel(12'd4095,  13'd0,      13'd4096);
    send_pixel(12'd100,   13'd0,      13'd8191);
    send_pixel(12'd4095,  13'd4096,   13'd4096);
    send_pixel(12'd1000,  13'd8191,   13'd8191);
    send_pixel(12'd3000,  13'd4097,   13'd1024);
    send_pixel(12'd200,   13'd1,      13'd1);
    send_pixel(12'd3500,  13'd2048,   13'd2047);
    send_pixel(12'd3500,  13'd2048,   13'd2048);
    send_pixel(12'd4000,  13'd4096,   13'd1);
    send_pixel(12'd1500,  13'd4095,   13'd4095);
    send_pixel(12'hAAA,   13'h1555,   13'h0AAA);
    send_pixel(12'h555,   13'h0AAA,   13'h1555);
  endtask

  // Random pixels in four phases with different idling on the two sides;
  // the sender waits for every result between phases.
  task automatic test_random_pixels();
    int unsigned  phase;
    int unsigned  roll;
    logic [11:0]  hue;
    logic [12:0]  sat;
    logic [12:0]  light;
    for (phase = 0; phase < 4; phase++) begin
      src_idle_en  = phase[0];
      sink_idle_en = phase[1];
      repeat (RANDOM_ITEMS / 4) begin
        hue  = 12'($urandom_range(0, 4095));
        roll = $urandom_range(0, 99);
        if (roll < 10)      sat = 13'd0;
        else if (roll < 20) sat = 13'($urandom_range(0, 8191));
        else if (roll < 28) sat = 13'd4096;
        else                sat = 13'($urandom_range(1, 4095));
        roll = $urandom_range(0, 99);
        if (roll < 10)      light = 13'($urandom_range(0, 8191));
        else if (roll < 15) light = 13'd0;
        else if (roll < 20) light = 13'd4096;
        else if (roll < 30) light = 13'($urandom_range(2044, 2052));
        else                light = 13'($urandom_range(0, 4096));
        send_pixel(hue, sat, light);
      end
      drain_results();
    end
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker.
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned run;
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 24);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = sink_idle_en ? idle_gap() : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Every accepted color is compared with the oldest expectation.
  always @(posedge clk_i) begin
    rgb_item_t got;
    rgb_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (rgb_expect_q.size() == 0) begin
        report_mismatch("unexpected color", int'(got), -1);
      end else begin
        want = rgb_expect_q.pop_front();
        if (got.red !== want.red)     report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue)   report_mismatch("blue", got.blue, want.blue);
        colors_checked++;
      end
    end
  end

  // The run is hung if neither side moves an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d colors outstanding.", rgb_expect_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    rst_ni         = 1'b0;
    mismatches     = 0;
    items_sent     = 0;
    colors_checked = 0;
    gray_items     = 0;
    clamped_items  = 0;
    idle_cycles    = 0;
    src_idle_en    = 1'b0;
    sink_idle_en   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hue_segments();
    test_range_limits();
    test_random_pixels();
    drain_results();

    $display("Converted %0d pixels and checked %0d colors, %0d of them gray.",
             items_sent, colors_checked, gray_items);
    $display("Ramp segment edges, %0d over-range inputs and four idling mixes covered.",
             clamped_items);
    if (mismatches == 0 && rgb_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d colors missing.", mismatches, rgb_expect_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
